// ===== src/nel_pkg.sv =====
// Package for the non-graphic escape and line wrap block.
// Holds the word types, register indexes, reset values and the digit helper.
// No dependencies; every other file of the block imports it.
`default_nettype none

package nel_pkg;

  localparam logic [7:0] NL_CHAR = 8'h0A;
  localparam logic [7:0] GRAPHIC_LO = 8'h21;
  localparam logic [7:0] GRAPHIC_HI = 8'h7E;

  localparam logic HEX_MODE_RST = 1'b1;
  localparam logic [7:0] LINE_WIDTH_RST = 8'd80;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b1;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_word_t;

  // One classified item: up to four characters, first in chars[0].
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      cnt;
  } nel_job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/nel_front.sv =====
// Front end: configuration registers, column tracking and classification of
// each input word into a job of one to four characters. Depends on nel_pkg.
`default_nettype none

module nel_front
  import nel_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                   in_push,
  input  wire in_word_t         in_data,
  input  wire                   q_full,
  output logic                  q_push,
  output nel_job_t              q_job
);

  logic       hex_mode_r;
  logic [7:0] line_width_r;
  logic [7:0] column_r;
  logic [7:0] column_nxt;

  logic            wrap;
  logic            fit_nl;
  logic            graphic;
  logic [1:0]      n_dig;
  logic [3:0][7:0] dig;
  logic [8:0]      col_sum;
  logic            nl;

  assign q_push = in_push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_mode_r   <= HEX_MODE_RST;
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEX_MODE:   hex_mode_r   <= cfg_wdata[0];
        CFG_LINE_WIDTH: line_width_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    graphic = (in_data.data_byte >= GRAPHIC_LO) && (in_data.data_byte <= GRAPHIC_HI);
    dig = '0;
    if (graphic) begin
      n_dig  = 2'd1;
      dig[0] = in_data.data_byte;
    end else if (hex_mode_r) begin
      if (in_data.data_byte[7:4] == 4'd0) begin
        n_dig  = 2'd1;
        dig[0] = digit_char(in_data.data_byte[3:0]);
      end else begin
        n_dig  = 2'd2;
        dig[0] = digit_char(in_data.data_byte[7:4]);
        dig[1] = digit_char(in_data.data_byte[3:0]);
      end
    end else begin
      if (in_data.data_byte[7:3] == 5'd0) begin
        n_dig  = 2'd1;
        dig[0] = digit_char({1'b0, in_data.data_byte[2:0]});
      end else if (in_data.data_byte[7:6] == 2'd0) begin
        n_dig  = 2'd2;
        dig[0] = digit_char({1'b0, in_data.data_byte[5:3]});
        dig[1] = digit_char({1'b0, in_data.data_byte[2:0]});
      end else begin
        n_dig  = 2'd3;
        dig[0] = digit_char({2'b0, in_data.data_byte[7:6]});
        dig[1] = digit_char({1'b0, in_data.data_byte[5:3]});
        dig[2] = digit_char({1'b0, in_data.data_byte[2:0]});
      end
    end

    wrap    = column_r >= line_width_r;
    col_sum = {1'b0, column_r} + {7'd0, n_dig};
    // Escapes that would overrun the line break first, unless a full-line
    // break already happened for this word.
    fit_nl  = !graphic && !wrap && (col_sum > {1'b0, line_width_r});
    nl      = (in_data.command == CMD_END) || wrap || fit_nl;

    // A newline goes first and pushes the digits up by one slot.
    if (nl) begin
      q_job.chars = {dig[2:0], NL_CHAR};
    end else begin
      q_job.chars = dig;
    end

    if (in_data.command == CMD_END) begin
      q_job.cnt  = 3'd1;
      column_nxt = '0;
    end else begin
      q_job.cnt  = {1'b0, n_dig} + {2'd0, nl};
      column_nxt = (nl ? 8'd0 : column_r) + {6'd0, n_dig};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
    end else if (q_push) begin
      column_r <= column_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/nel_queue.sv =====
// Short job queue between the front end and the character serializer.
// Flip-flop storage with head read at the read pointer. Depends on nel_pkg.
`default_nettype none

module nel_queue
  import nel_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  wire nel_job_t  push_job,
  output logic           full,
  input  wire            pop,
  output logic           valid,
  output nel_job_t       head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nel_job_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = count_r == CW'(DEPTH);
  assign valid   = count_r != '0;
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/nel_back.sv =====
// Back end: holds one job and sends its characters one per cycle while out_pop
// is high on the result channel, marking the final one. Depends on nel_pkg.
`default_nettype none

module nel_back
  import nel_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            q_valid,
  input  wire nel_job_t  q_head,
  output logic           q_pop,
  output logic           out_empty,
  input  wire            out_pop,
  output out_word_t      out_data
);

  logic       busy_r;
  nel_job_t   job_r;
  logic [1:0] idx_r;
  logic       is_last;
  logic       take;

  assign is_last         = ({1'b0, idx_r} + 3'd1) == job_r.cnt;
  assign out_empty       = !busy_r;
  assign out_data.out_char = job_r.chars[idx_r];
  assign out_data.last   = is_last;
  // Reload when idle or when the final character leaves this cycle.
  assign take            = !busy_r || (out_pop && is_last);
  assign q_pop           = take && q_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (take) begin
      busy_r <= q_valid;
      idx_r  <= '0;
    end else if (out_pop) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/nongraphic_escape_line_wrapper.sv =====
// Top level of the non-graphic escape and line wrap block.
// Instantiates nel_front, nel_queue and nel_back; depends on nel_pkg.
//
// Usage: bytes arrive as words on the input queue port (in_push / in_full).
// A word with command 0 carries a data byte; command 1 ends the input and
// produces one final newline. Graphic bytes (0x21 to 0x7E) pass through,
// every other byte is printed as lowercase hex or octal digits without
// leading zeros. A newline is inserted when the column has reached the line
// width, or when an escape's digits would not fit on the current line.
// Each input word yields one to four characters on the result queue port
// (out_empty / out_pop); the last character of a word has last set.
// Configuration (hex_mode at index 0, line_width at index 1) is written
// through cfg_we / cfg_index / cfg_wdata while the block is idle.
// The front end takes one word per cycle while the queue has room. Each word is
// held in the job queue, then loaded into the back end's job register, and only
// then put out on the result port, one character per cycle while out_pop is high.
// Reset (rst_n, synchronous) empties the queue, clears the column to zero and
// restores hex mode and a line width of 80. When the receiver stops popping,
// the job queue fills and in_full rises; nothing is dropped.
`default_nettype none

module nongraphic_escape_line_wrapper
  import nel_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                   in_push,
  output logic                  in_full,
  input  wire in_word_t         in_data,
  output logic                  out_empty,
  input  wire                   out_pop,
  output out_word_t             out_data
);

  // Front end pushes classified jobs, back end drains them.
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  nel_job_t q_job;
  nel_job_t q_head;

  assign in_full = q_full;

  nel_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  nel_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  nel_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for nongraphic_escape_line_wrapper.
// Holds the clock, reset, word driver, character monitor, escape predictor and watchdog.
// Depends on nel_pkg for the word types, command codes and register indexes.

module tb_top;
  import nel_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake before we give up
  localparam int TAIL_CYCLES = 8;     // quiet time after the last character
  localparam int NUM_RAND_PHASES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_word_t              in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_word_t             out_data;

  // Words waiting to be offered to the block, and characters we expect back.
  in_word_t  pending_words[$];
  out_word_t expected_chars[$];

  // Shadow of the block's registers and column counter.
  logic       hex_on = HEX_MODE_RST;
  logic [7:0] wrap_at = LINE_WIDTH_RST;
  logic [7:0] col_pos = 8'd0;

  // Percentage of cycles in which each side holds back; zero gives a steady stream.
  int unsigned idle_pct = 36;
  int errors = 0;
  int words_sent = 0;
  int chars_checked = 0;
  int settings_used = 0;
  int stall_cycles = 0;

  nongraphic_escape_line_wrapper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Lowercase ASCII digit for a value of 0 to 15.
  function automatic logic [7:0] ascii_digit(int d);
    if (d < 10) begin
      return 8'(8'h30 + d);
    end
    return 8'(8'h61 + d - 10);
  endfunction

  // Works out the characters one accepted word produces and queues them.
  // The column counter is updated here, so this must run once per accepted word,
  // in acceptance order.
  function automatic void predict_escape(in_word_t w);
    logic [7:0] seq[$];
    logic [7:0] digs[$];
    bit         wrapped;
    int         v;
    int         radix;
    out_word_t  c;
    wrapped = 1'b0;
    if (w.command == CMD_END) begin
      seq.push_back(NL_CHAR);
      col_pos = 8'd0;
    end else begin
      // A full line wraps first; >= also catches a width lowered under the column.
      if (col_pos >= wrap_at) begin
        seq.push_back(NL_CHAR);
        col_pos = 8'd0;
        wrapped = 1'b1;
      end
      if (w.data_byte >= GRAPHIC_LO && w.data_byte <= GRAPHIC_HI) begin
        seq.push_back(w.data_byte);
        col_pos = col_pos + 8'd1;
      end else begin
        v = w.data_byte;
        radix = hex_on ? 16 : 8;
        do begin
          digs.push_front(ascii_digit(v % radix));
          v = v / radix;
        end while (v != 0);
        // Digits that would run past the line start a new one, but never a second
        // newline after a full-line wrap in the same word.
        if (!wrapped && int'(col_pos) + digs.size() > int'(wrap_at)) begin
          seq.push_back(NL_CHAR);
          col_pos = 8'd0;
        end
        foreach (digs[i]) seq.push_back(digs[i]);
        col_pos = col_pos + 8'(digs.size());
      end
    end
    foreach (seq[i]) begin
      c.out_char = seq[i];
      c.last = (i == seq.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Driver: offers queued words, holds a word while the block is full, and idles
  // at random. The prediction is made at the edge where the word is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_escape(in_data);
        words_sent++;
      end
      if (!in_push || !in_full) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_push <= 1'b1;
          in_data <= pending_words.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pops characters at random and compares each one with the oldest
  // expectation, field by field.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_chars.size() == 0) begin
          $error("character 0x%02h arrived with nothing expected", out_data.out_char);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_data.out_char !== want.out_char) begin
            $error("out_char: expected 0x%02h, got 0x%02h", want.out_char, out_data.out_char);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            errors++;
          end
        end
      end
      out_pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: a long run of cycles with no handshake on any port means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Waits until every queued word is accepted and every expected character popped.
  // Since each word yields at least one character, the block is then idle.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_push || expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HEX_MODE:   hex_on = val[0];
      CFG_LINE_WIDTH: wrap_at = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drains the block, then loads a new escape radix and line width. The drain is
  // also where the sender sits still until every expected character is back.
  task automatic set_mode(logic hex, logic [7:0] width);
    wait_drained();
    write_reg(CFG_HEX_MODE, CFG_DATA_W'(hex));
    write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(width));
    settings_used++;
  endtask

  task automatic queue_byte(logic [7:0] b);
    in_word_t w;
    w.command = CMD_DATA;
    w.data_byte = b;
    pending_words.push_back(w);
  endtask

  task automatic queue_end(logic [7:0] junk);
    in_word_t w;
    w.command = CMD_END;
    w.data_byte = junk;
    pending_words.push_back(w);
  endtask

  // Random word: mostly data bytes, weighted toward both graphic and escaped
  // values, with an occasional end command.
  function automatic in_word_t random_word();
    in_word_t w;
    w.command = ($urandom_range(9) == 0) ? CMD_END : CMD_DATA;
    case ($urandom_range(3))
      0, 1: w.data_byte = 8'($urandom_range(255));
      2:    w.data_byte = 8'($urandom_range(GRAPHIC_HI, GRAPHIC_LO));
      default: begin
        if ($urandom_range(1) == 0) begin
          w.data_byte = 8'($urandom_range(GRAPHIC_LO - 1, 0));
        end else begin
          w.data_byte = 8'($urandom_range(255, GRAPHIC_HI + 1));
        end
      end
    endcase
    return w;
  endfunction

  initial begin
    logic        phase_hex[NUM_RAND_PHASES];
    logic [7:0]  phase_width[NUM_RAND_PHASES];
    int          phase_words[NUM_RAND_PHASES];
    // Random phases run from widths far below the range up to the widest line.
    phase_hex   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_width = '{8'd255, 8'd0, 8'd3, 8'd2, 8'd4, 8'd12, 8'd80, 8'd255};
    phase_words = '{12, 10, 10, 10, 12, 20, 12, 10};
    phase_width[5] = 8'($urandom_range(30, 5));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: hex escapes and a line of 80. Covers both byte extremes, the
    // edges of the graphic range and the one-to-two hex digit boundary. The end
    // command carries a junk byte that must be ignored.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h21);
    queue_byte(8'h7E);
    queue_byte(8'h20);
    queue_byte(8'h7F);
    queue_byte(8'h0F);
    queue_byte(8'h10);
    queue_byte(8'h80);
    queue_end(8'hAA);

    // Octal on a line of four: escapes that do not fit, a full line ahead of an
    // escape, and the one-, two- and three-digit octal boundaries.
    set_mode(1'b0, 8'd4);
    queue_byte(8'h41);
    queue_byte(8'h42);
    queue_byte(8'h43);
    queue_byte(8'hFF);
    queue_byte(8'h41);
    queue_byte(8'h00);
    queue_byte(8'h07);
    queue_byte(8'h08);
    queue_byte(8'h40);
    queue_byte(8'h3F);
    queue_end(8'h00);

    // A line narrower than the digits: a full-line wrap is not followed by a
    // second newline, and the digits overrun the fresh line.
    set_mode(1'b1, 8'd1);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_end(8'hFF);

    // Random phases. The column carries over from one phase to the next, so a
    // narrower width often starts below the current column.
    for (int p = 0; p < NUM_RAND_PHASES; p++) begin
      set_mode(phase_hex[p], phase_width[p]);
      // The sixth phase runs with no idling on either side.
      idle_pct = (p == 5) ? 0 : 36;
      repeat (phase_words[p]) pending_words.push_back(random_word());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words and checked %0d characters under %0d register settings,",
             words_sent, chars_checked, settings_used);
    $display("covering hex and octal escapes, line widths from 0 to 255 and end commands.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
